FILE: rtl/core/timestamp_grid_match_cost_unit_macros.svh
// Assertion helpers used by tgmc_seq.
`ifndef TIMESTAMP_GRID_MATCH_COST_UNIT_MACROS_SVH
`define TIMESTAMP_GRID_MATCH_COST_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TGMC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TGMC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tgmc_pkg.sv
package tgmc_pkg;

    localparam int MAX_N = 256;
    localparam int MAX_M = 1024;

    localparam int STAMP_W = 32;
    localparam int COST_W  = 40;
    localparam int GRID_W  = 34;
    localparam int PEN_W   = 16;
    localparam int CNT_W   = $clog2(MAX_N + 1);
    localparam int IDX_W   = $clog2(MAX_N);
    localparam int LEN_W   = $clog2(MAX_M + 2);
    localparam int EXC_W   = LEN_W + PEN_W;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // register file
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_INTERVAL       = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_START_POINT    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_ADD_PENALTY    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_DELETE_PENALTY = REG_IDX_W'(3);

    typedef struct packed {
        logic [PEN_W-1:0]   interval;
        logic [STAMP_W-1:0] start_point;
        logic [PEN_W-1:0]   add_penalty;
        logic [PEN_W-1:0]   delete_penalty;
    } cfg_t;

    typedef struct packed {
        logic dist_en;
        logic sum_en;
    } cell_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
        logic [LEN_W-1:0]  len;
        logic              limit;
    } result_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

FILE: rtl/core/tgmc_regs.sv
module tgmc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgmc_pkg::ADDR_W-1:0]   paddr,
    input  logic [tgmc_pkg::DATA_W-1:0]   pwdata,
    output logic [tgmc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tgmc_pkg::cfg_t                cfg
);
    import tgmc_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval       <= PEN_W'(1);
            cfg_reg.start_point    <= '0;
            cfg_reg.add_penalty    <= PEN_W'(100);
            cfg_reg.delete_penalty <= PEN_W'(100);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_INTERVAL:       cfg_reg.interval       <= pwdata[PEN_W-1:0];
                REG_START_POINT:    cfg_reg.start_point    <= pwdata[STAMP_W-1:0];
                REG_ADD_PENALTY:    cfg_reg.add_penalty    <= pwdata[PEN_W-1:0];
                REG_DELETE_PENALTY: cfg_reg.delete_penalty <= pwdata[PEN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INTERVAL:       prdata = DATA_W'(cfg_reg.interval);
            REG_START_POINT:    prdata = DATA_W'(cfg_reg.start_point);
            REG_ADD_PENALTY:    prdata = DATA_W'(cfg_reg.add_penalty);
            REG_DELETE_PENALTY: prdata = DATA_W'(cfg_reg.delete_penalty);
        endcase
    end

endmodule

FILE: rtl/core/tgmc_cell_unit.sv
module tgmc_cell_unit (
    input  logic                          clk,
    input  tgmc_pkg::cell_ctl_t           ctl,
    input  logic [tgmc_pkg::STAMP_W-1:0]  stamp,
    input  logic [tgmc_pkg::GRID_W-1:0]   grid,
    input  logic [tgmc_pkg::COST_W-1:0]   up,
    input  logic [tgmc_pkg::COST_W-1:0]   diag,
    input  logic [tgmc_pkg::COST_W-1:0]   left,
    input  logic [tgmc_pkg::PEN_W-1:0]    add_penalty,
    input  logic [tgmc_pkg::PEN_W-1:0]    delete_penalty,
    output logic [tgmc_pkg::COST_W-1:0]   cell_min
);
    import tgmc_pkg::*;

    logic [GRID_W-1:0] stamp_ext;
    logic [GRID_W-1:0] dist_next;
    logic [GRID_W-1:0] dist_reg;
    logic [COST_W-1:0] mv_reg;
    logic [COST_W-1:0] ad_reg;
    logic [COST_W-1:0] dl_reg;
    logic [COST_W-1:0] pair_min;

    // distance from the stamp to the current grid point
    assign stamp_ext = GRID_W'(stamp);
    assign dist_next = (stamp_ext > grid) ? (stamp_ext - grid) : (grid - stamp_ext);

    always_ff @(posedge clk)
    begin
        if (ctl.dist_en)
            dist_reg <= dist_next;
        if (ctl.sum_en)
        begin
            mv_reg <= sat_add(diag, COST_W'(dist_reg));
            ad_reg <= sat_add(up, COST_W'(add_penalty));
            dl_reg <= sat_add(left, COST_W'(delete_penalty));
        end
    end

    assign pair_min = (mv_reg < ad_reg) ? mv_reg : ad_reg;
    assign cell_min = (pair_min < dl_reg) ? pair_min : dl_reg;

endmodule

FILE: rtl/core/tgmc_seq.sv
`include "timestamp_grid_match_cost_unit_macros.svh"

module tgmc_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tgmc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tgmc_pkg::STAMP_W-1:0]  stamp,
    input  logic                          last_item,
    output tgmc_pkg::result_t             res,
    input  logic                          res_take
);
    import tgmc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_DIST  = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_MIN   = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic               lost_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   m_reg;
    logic [GRID_W-1:0]  grid_reg;
    logic [EXC_W-1:0]   col0_reg;
    logic [EXC_W-1:0]   excess_reg;
    logic [COST_W-1:0]  best_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic               cut_reg;
    logic [COST_W-1:0]  left_reg;
    logic [COST_W-1:0]  diag_reg;
    logic [COST_W-1:0]  up_reg;

    logic [STAMP_W-1:0] stamp_mem [MAX_N];
    logic [COST_W-1:0]  col_mem   [MAX_N];
    logic [STAMP_W-1:0] stamp_q;
    logic [COST_W-1:0]  col_q;

    logic               accept;
    logic               room;
    logic               idx_last;
    logic               allowed;
    logic               at_limit;
    logic [EXC_W-1:0]   col0_sum;
    logic [COST_W-1:0]  init_sum;
    logic [COST_W-1:0]  cell_min;
    cell_ctl_t          cell_ctl;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign room     = (count_reg < CNT_W'(MAX_N));
    assign idx_last = ({1'b0, idx_reg} == (count_reg - CNT_W'(1)));
    assign allowed  = (m_reg <= LEN_W'(count_reg)) || (COST_W'(excess_reg) <= best_reg);
    assign at_limit = (m_reg == LEN_W'(MAX_M + 1));
    assign col0_sum = col0_reg + EXC_W'(cfg.add_penalty);
    assign init_sum = sat_add(left_reg, COST_W'(cfg.delete_penalty));

    assign cell_ctl.dist_en = (state_reg == S_DIST);
    assign cell_ctl.sum_en  = (state_reg == S_SUM);

    assign res.valid = (state_reg == S_DONE);
    assign res.cost  = best_reg;
    assign res.len   = best_len_reg;
    assign res.limit = cut_reg || lost_reg;

    tgmc_cell_unit u_cell (
        .clk            (clk),
        .ctl            (cell_ctl),
        .stamp          (stamp_q),
        .grid           (grid_reg),
        .up             (up_reg),
        .diag           (diag_reg),
        .left           (left_reg),
        .add_penalty    (cfg.add_penalty),
        .delete_penalty (cfg.delete_penalty),
        .cell_min       (cell_min)
    );

    // stamp and column stores, one registered read each
    always_ff @(posedge clk)
    begin
        if (accept && room)
            stamp_mem[count_reg[IDX_W-1:0]] <= stamp;
        stamp_q <= stamp_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
            col_mem[idx_reg] <= init_sum;
        else if (state_reg == S_MIN)
            col_mem[idx_reg] <= cell_min;
        col_q <= col_mem[idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && last_item) state_next = S_INIT;
            S_INIT:  if (idx_last) state_next = S_CHECK;
            S_CHECK:
            begin
                if (at_limit || !allowed)
                    state_next = S_DONE;
                else
                    state_next = S_RD;
            end
            S_RD:    state_next = S_DIST;
            S_DIST:  state_next = S_SUM;
            S_SUM:   state_next = S_MIN;
            S_MIN:   state_next = idx_last ? S_END : S_RD;
            S_END:   state_next = S_CHECK;
            S_DONE:  if (res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            lost_reg     <= 1'b0;
            idx_reg      <= '0;
            m_reg        <= '0;
            grid_reg     <= '0;
            col0_reg     <= '0;
            excess_reg   <= '0;
            best_reg     <= COST_MAX;
            best_len_reg <= '0;
            cut_reg      <= 1'b0;
            left_reg     <= '0;
            diag_reg     <= '0;
            up_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                            count_reg <= count_reg + CNT_W'(1);
                        else
                            lost_reg <= 1'b1;
                    end
                    // prime the sweep
                    idx_reg      <= '0;
                    left_reg     <= '0;
                    m_reg        <= LEN_W'(1);
                    grid_reg     <= GRID_W'(cfg.start_point);
                    col0_reg     <= '0;
                    excess_reg   <= '0;
                    best_reg     <= COST_MAX;
                    best_len_reg <= '0;
                    cut_reg      <= 1'b0;
                end
                S_INIT:
                begin
                    left_reg <= init_sum;
                    idx_reg  <= idx_reg + IDX_W'(1);
                end
                S_CHECK:
                begin
                    cut_reg  <= at_limit && allowed;
                    idx_reg  <= '0;
                    diag_reg <= COST_W'(col0_reg);
                    left_reg <= COST_W'(col0_sum);
                    if (!at_limit && allowed)
                        col0_reg <= col0_sum;
                end
                S_DIST:  up_reg <= col_q;
                S_MIN:
                begin
                    left_reg <= cell_min;
                    diag_reg <= up_reg;
                    idx_reg  <= idx_reg + IDX_W'(1);
                end
                S_END:
                begin
                    if (left_reg < best_reg)
                    begin
                        best_reg     <= left_reg;
                        best_len_reg <= m_reg;
                    end
                    if (m_reg >= LEN_W'(count_reg))
                        excess_reg <= excess_reg + EXC_W'(cfg.add_penalty);
                    grid_reg <= grid_reg + GRID_W'(cfg.interval);
                    m_reg    <= m_reg + LEN_W'(1);
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        count_reg <= '0;
                        lost_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    `TGMC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_N), "stamp count beyond store depth")
    `TGMC_ASSERT_SAME(a_cell_in_range, clk, rst_n, state_reg == S_MIN, {1'b0, idx_reg} < count_reg, "cell index past stamp count")
    `TGMC_ASSERT_SAME(a_col_in_range, clk, rst_n, (state_reg == S_CHECK) && (state_next == S_RD), m_reg <= LEN_W'(MAX_M), "grid length beyond limit")
    `TGMC_ASSERT_NEXT(a_best_falls, clk, rst_n, state_reg == S_END, best_reg <= $past(best_reg), "best cost rose during sweep")

endmodule

FILE: rtl/core/timestamp_grid_match_cost_unit.sv
// Equal-interval timestamp repair cost. Stamps arrive one item per cycle while the
// unit is idle and are held in a 256-entry store (more are dropped and flag
// limit_hit). The item with last_item set starts an edit-distance sweep that
// aligns the n stored stamps to grids start_point + (k-1)*interval for k = 1, 2
// and onward and returns the least cost and the first k reaching it. One DP cell
// unit and the single-port column store set the pace: each cell steps through
// read, distance, three saturating sums, minimum and write back, and a sweep
// covers K grid lengths, K at most 1024. The sweep stops once (k-n)*add_penalty
// exceeds the best cost, or after k = 1024 with limit_hit set. No item is taken
// while a sweep runs; a result waits in the output register while loading of the
// next series goes on.
module timestamp_grid_match_cost_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgmc_pkg::ADDR_W-1:0]   paddr,
    input  logic [tgmc_pkg::DATA_W-1:0]   pwdata,
    output logic [tgmc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tgmc_pkg::STAMP_W-1:0]  stamp,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tgmc_pkg::COST_W-1:0]   least_cost,
    output logic [tgmc_pkg::LEN_W-1:0]    best_length,
    output logic                          limit_hit
);
    import tgmc_pkg::*;

    cfg_t              cfg;
    result_t           res;
    logic              res_take;
    logic              out_valid_reg;
    logic [COST_W-1:0] least_cost_reg;
    logic [LEN_W-1:0]  best_length_reg;
    logic              limit_hit_reg;

    tgmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgmc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .stamp     (stamp),
        .last_item (last_item),
        .res       (res),
        .res_take  (res_take)
    );

    // take a finished result once the output register is free or draining
    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // hold the payload until the item is taken
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            least_cost_reg  <= res.cost;
            best_length_reg <= res.len;
            limit_hit_reg   <= res.limit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign least_cost  = least_cost_reg;
    assign best_length = best_length_reg;
    assign limit_hit   = limit_hit_reg;

endmodule
